// ===== hw/rtl/utf16_to_utf32_decoder_macros.svh =====
// Assertion macros for the UTF-16 to UTF-32 decoder.
// Included by the top level; the bodies compile away under SYNTHESIS.
`ifndef UTF16_TO_UTF32_DECODER_MACROS_SVH
`define UTF16_TO_UTF32_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Checked property, suspended while reset is high.
`define U16D_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also evaluated during reset.
`define U16D_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define U16D_ASSERT(label, clk, rst, prop, msg)
`define U16D_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/u16d_pkg.sv =====
// Types and constants shared by the UTF-16 to UTF-32 decoder modules.
// No dependencies.
package u16d_pkg;

   localparam int unsigned COUNT_LIMIT = 1048576;

   localparam int unsigned UNIT_W  = 16;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned COUNT_W = 21;
   localparam int unsigned BITS_W  = 10;

   // Reset limit, saturated to the register width.
   localparam int unsigned LIMIT_MAX_INT   = (1 << COUNT_W) - 1;
   localparam int unsigned LIMIT_RESET_INT =
      (COUNT_LIMIT > LIMIT_MAX_INT) ? LIMIT_MAX_INT : COUNT_LIMIT;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(LIMIT_RESET_INT);

   localparam logic [UNIT_W-1:0] HIGH_FIRST = 16'hD800;
   localparam logic [UNIT_W-1:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [UNIT_W-1:0] LOW_FIRST  = 16'hDC00;
   localparam logic [UNIT_W-1:0] LOW_LAST   = 16'hDFFF;
   localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h010000;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_LIMIT_ZERO     = 3'd1,
      ST_LIMIT_EXCEEDED = 3'd2,
      ST_HIGH_AT_END    = 3'd3,
      ST_BAD_PAIR       = 3'd4,
      ST_LONE_LOW       = 3'd5
   } status_type;

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              end_of_text;
   } unit_type;

   typedef struct packed {
      logic [BITS_W-1:0]  pending_high_bits;
      logic               high_pending;
      logic [COUNT_W-1:0] emitted_count;
      status_type         error_code;
   } text_state_type;

   typedef struct packed {
      logic [CP_W-1:0] codepoint;
      logic            codepoint_valid;
      status_type      status;
      logic            text_done;
   } result_type;

endpackage

// ===== hw/rtl/utf16_to_utf32_decoder.sv =====
// Top level of the UTF-16 to UTF-32 decoder: input register, decode step, result register.
// Depends on u16d_pkg, u16d_in_reg, u16d_decode and utf16_to_utf32_decoder_macros.svh.
//
// Usage:
//  - req_* carries one UTF-16 code unit per transaction; req_end_of_text marks
//    the last unit of a text. rsp_* returns exactly one result per unit:
//    an optional code point, the sticky status of the text, and text_done.
//  - csr_write_enable/csr_write_data set max_codepoints (21 bits). Write it
//    only while no transaction is in flight; zero makes every text fail.
//  - Path: a unit accepted into the input register is decoded into the result
//    register once that register is free, i.e. two register stages.
//  - Throughput: one unit per cycle while rsp_ready is high. The text state (pending
//    high surrogate, count, first error) is updated in the same cycle a unit moves
//    from the input register to the result register, so the next unit sees it at once.
//  - Stall: when rsp_ready is low the result is held; the input register still
//    takes one more unit, then req_ready drops until the result drains.
//  - Reset: both stages empty, limit back to its reset value, text state clear.
//  - After a text_done result the state is clear for the next text.
`include "utf16_to_utf32_decoder_macros.svh"

module utf16_to_utf32_decoder
   import u16d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_write_enable,
   input  logic [COUNT_W-1:0] csr_write_data,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [UNIT_W-1:0]  req_code_unit,
   input  logic               req_end_of_text,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CP_W-1:0]    rsp_codepoint,
   output logic               rsp_codepoint_valid,
   output logic [2:0]         rsp_status,
   output logic               rsp_text_done
);

   logic [COUNT_W-1:0] limit_ff, limit_in;
   text_state_type     state_ff, state_in, state_step;
   result_type         result_ff, result_in, result_step;
   logic               rsp_valid_ff, rsp_valid_in;
   unit_type           req_unit, held_unit;
   logic               held_valid;
   logic               advance;   // held unit is decoded into the result register

   assign req_unit = '{code_unit: req_code_unit, end_of_text: req_end_of_text};

   // result register is free, or frees this cycle
   assign advance = held_valid && (!rsp_valid_ff || rsp_ready);

   u16d_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_unit),
      .take       (advance),
      .held_valid (held_valid),
      .held_data  (held_unit)
   );

   u16d_decode u_decode (
      .unit           (held_unit),
      .state          (state_ff),
      .max_codepoints (limit_ff),
      .state_next     (state_step),
      .result         (result_step)
   );

   always_comb begin
      limit_in = csr_write_enable ? csr_write_data : limit_ff;
      state_in = advance ? state_step : state_ff;
      result_in = advance ? result_step : result_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         state_ff     <= '{pending_high_bits: '0, high_pending: 1'b0,
                           emitted_count: '0, error_code: ST_OK};
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_codepoint       = result_ff.codepoint;
   assign rsp_codepoint_valid = result_ff.codepoint_valid;
   assign rsp_status          = result_ff.status;
   assign rsp_text_done       = result_ff.text_done;

   // A delivered code point always comes with an error-free status.
   `U16D_ASSERT(a_cp_status_ok, clock, reset, rsp_valid && rsp_codepoint_valid |-> rsp_status == ST_OK, "code point with error status")

   // Surrogate values never leave as code points.
   `U16D_ASSERT(a_cp_not_surrogate, clock, reset, rsp_valid && rsp_codepoint_valid |-> !(rsp_codepoint >= 21'h00D800 && rsp_codepoint <= 21'h00DFFF), "surrogate emitted")

   // Decoding the last unit of a text leaves the text state clear.
   `U16D_ASSERT(a_state_cleared, clock, reset, advance && held_unit.end_of_text |=> state_ff.emitted_count == '0 && !state_ff.high_pending && state_ff.error_code == ST_OK, "state not cleared at end of text")

endmodule

// ===== hw/rtl/u16d_in_reg.sv =====
// Input register of the decoder: one transaction deep, refills in the cycle it drains.
// Depends on u16d_pkg.
module u16d_in_reg
   import u16d_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  unit_type req_data,
   input  logic     take,       // downstream consumes the held unit this cycle
   output logic     held_valid,
   output unit_type held_data
);

   logic     valid_ff, valid_in;
   unit_type data_ff, data_in;

   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign held_valid = valid_ff;
   assign held_data  = data_ff;

endmodule

// ===== hw/rtl/u16d_decode.sv =====
// One decode step: classifies a code unit against the text state and forms the result.
// Purely combinational. Depends on u16d_pkg.
module u16d_decode
   import u16d_pkg::*;
(
   input  unit_type           unit,
   input  text_state_type     state,
   input  logic [COUNT_W-1:0] max_codepoints,
   output text_state_type     state_next,
   output result_type         result
);

   logic is_high, is_low;
   text_state_type nxt;

   assign is_high = unit.code_unit inside {[HIGH_FIRST:HIGH_LAST]};
   assign is_low  = unit.code_unit inside {[LOW_FIRST:LOW_LAST]};

   always_comb begin
      nxt                    = state;
      result.codepoint       = '0;
      result.codepoint_valid = 1'b0;
      if (state.error_code == ST_OK) begin
         if (max_codepoints == '0) begin
            nxt.error_code = ST_LIMIT_ZERO;
         end else if (state.high_pending) begin
            if (is_low) begin
               result.codepoint = SUPP_BASE +
                  {1'b0, state.pending_high_bits, unit.code_unit[BITS_W-1:0]};
               result.codepoint_valid = 1'b1;
               nxt.emitted_count      = state.emitted_count + 1'b1;
               nxt.high_pending       = 1'b0;
               nxt.pending_high_bits  = '0;
            end else begin
               nxt.error_code = ST_BAD_PAIR;
            end
         end else if (state.emitted_count >= max_codepoints) begin
            nxt.error_code = ST_LIMIT_EXCEEDED;
         end else if (is_high) begin
            if (unit.end_of_text) begin
               nxt.error_code = ST_HIGH_AT_END;
            end else begin
               nxt.pending_high_bits = unit.code_unit[BITS_W-1:0];
               nxt.high_pending      = 1'b1;
            end
         end else if (is_low) begin
            nxt.error_code = ST_LONE_LOW;
         end else begin
            result.codepoint       = {{(CP_W-UNIT_W){1'b0}}, unit.code_unit};
            result.codepoint_valid = 1'b1;
            nxt.emitted_count      = state.emitted_count + 1'b1;
         end
      end
      result.status    = nxt.error_code;
      result.text_done = unit.end_of_text;
      // last unit of a text starts the next one clean
      if (unit.end_of_text) begin
         state_next = '{pending_high_bits: '0, high_pending: 1'b0,
                        emitted_count: '0, error_code: ST_OK};
      end else begin
         state_next = nxt;
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for utf16_to_utf32_decoder: directed table, then random texts.
// Depends on u16d_pkg and the decoder RTL; needs no other file.
module testbench
   import u16d_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_UNITS = 600;
   localparam int PHASE_UNITS  = 70;
   localparam int REPORT_MAX   = 10;

   // One row of the directed table. When typed is set, want holds the
   // result read straight off the spec; otherwise the predictor decides.
   typedef struct packed {
      logic [UNIT_W-1:0]  unit;
      logic               eot;
      logic               load;      // write max_codepoints before this row
      logic [COUNT_W-1:0] lim;
      logic               typed;
      result_type         want;
   } unit_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [COUNT_W-1:0] csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [UNIT_W-1:0]  req_code_unit = '0;
   logic               req_end_of_text = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [CP_W-1:0]    rsp_codepoint;
   logic               rsp_codepoint_valid;
   logic [2:0]         rsp_status;
   logic               rsp_text_done;

   // Predictor state: mirrors the decoder's text state and limit register.
   logic [COUNT_W-1:0] cp_limit = LIMIT_RESET;
   logic [BITS_W-1:0]  pend_bits = '0;
   logic               pend_flag = 1'b0;
   logic [COUNT_W-1:0] cp_count = '0;
   status_type         text_err = ST_OK;

   result_type   decoded_queue[$];
   unit_row_type unit_table[$];
   int           units_sent = 0;
   int           fail_count = 0;
   bit           send_steady = 1'b0;   // sender idles never while set
   bit           ready_steady = 1'b0;  // receiver stalls never while set
   int           stall_left = 0;

   utf16_to_utf32_decoder dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_code_unit       (req_code_unit),
      .req_end_of_text     (req_end_of_text),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_codepoint       (rsp_codepoint),
      .rsp_codepoint_valid (rsp_codepoint_valid),
      .rsp_status          (rsp_status),
      .rsp_text_done       (rsp_text_done)
   );

   // 2 ns clock.
   initial begin
      forever #1 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 92) return $urandom_range(1, 3);
      else return $urandom_range(8, 30);
   endfunction

   // Limit choice per phase; extremes show up often.
   function automatic logic [COUNT_W-1:0] pick_limit();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return COUNT_W'(1);
         2: return COUNT_W'($urandom_range(2, 8));
         3: return LIMIT_RESET;
         4: return {COUNT_W{1'b1}};
         default: return COUNT_W'($urandom_range(1, 20));
      endcase
   endfunction

   // Decode one code unit against the predictor state. Order of checks
   // matters: a sticky error wins, then limit zero, then the held high half
   // (its low half skips the limit check), then the limit, then the unit kind.
   function automatic result_type decode_unit(input logic [UNIT_W-1:0] u, input logic e);
      result_type r;
      logic       is_high;
      logic       is_low;
      is_high = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
      is_low  = (u >= LOW_FIRST) && (u <= LOW_LAST);
      r.codepoint       = '0;
      r.codepoint_valid = 1'b0;
      if (text_err == ST_OK) begin
         if (cp_limit == '0) begin
            text_err = ST_LIMIT_ZERO;
         end else if (pend_flag) begin
            if (is_low) begin
               r.codepoint = SUPP_BASE + (CP_W'(pend_bits) << 10) + CP_W'(u - LOW_FIRST);
               r.codepoint_valid = 1'b1;
               cp_count  = cp_count + 1'b1;
               pend_flag = 1'b0;
               pend_bits = '0;
            end else begin
               text_err = ST_BAD_PAIR;
            end
         end else if (cp_count >= cp_limit) begin
            text_err = ST_LIMIT_EXCEEDED;
         end else if (is_high) begin
            if (e) begin
               text_err = ST_HIGH_AT_END;
            end else begin
               pend_bits = BITS_W'(u - HIGH_FIRST);
               pend_flag = 1'b1;
            end
         end else if (is_low) begin
            text_err = ST_LONE_LOW;
         end else begin
            r.codepoint = CP_W'(u);
            r.codepoint_valid = 1'b1;
            cp_count = cp_count + 1'b1;
         end
      end
      r.status    = text_err;
      r.text_done = e;
      // end of text clears everything but the limit
      if (e) begin
         pend_bits = '0;
         pend_flag = 1'b0;
         cp_count  = '0;
         text_err  = ST_OK;
      end
      return r;
   endfunction

   task automatic add_row(input logic [UNIT_W-1:0] u, input logic e, input logic load,
                          input logic [COUNT_W-1:0] lim, input logic typed,
                          input logic [CP_W-1:0] cp, input logic cpv,
                          input status_type st);
      unit_row_type row;
      row.unit  = u;
      row.eot   = e;
      row.load  = load;
      row.lim   = lim;
      row.typed = typed;
      row.want.codepoint       = cp;
      row.want.codepoint_valid = cpv;
      row.want.status          = st;
      row.want.text_done       = e;
      unit_table.insert(unit_table.size(), row);
   endtask

   // Drain the pipe, then write the limit. This is also the sender's
   // pause until every outstanding result is back.
   task automatic set_limit(input logic [COUNT_W-1:0] v);
      @(negedge clock) req_valid <= 1'b0;
      while (decoded_queue.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock) csr_write_enable <= 1'b0;
      cp_limit = v;
   endtask

   // Offer one unit, hold it until the transaction completes, then queue
   // the result it must produce.
   task automatic send_unit(input logic [UNIT_W-1:0] u, input logic e,
                            input logic typed, input result_type want);
      int         gap;
      result_type pred;
      gap = send_steady ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_code_unit   <= u;
      req_end_of_text <= e;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = decode_unit(u, e);
      decoded_queue.insert(decoded_queue.size(), typed ? want : pred);
      units_sent++;
   endtask

   // One random text: mostly well-formed BMP units and surrogate pairs,
   // sometimes with a stray unit, a stray surrogate or a cut-off tail.
   task automatic send_text();
      logic [UNIT_W-1:0] units[$];
      int                n;
      int                kind;
      n    = $urandom_range(1, 10);
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
         repeat (n) units.insert(units.size(), UNIT_W'($urandom_range(0, 16'hFFFF)));
      end else begin
         repeat (n) begin
            if ($urandom_range(0, 9) < 7) begin
               if ($urandom_range(0, 1) == 0)
                  units.insert(units.size(), UNIT_W'($urandom_range(0, 16'hD7FF)));
               else
                  units.insert(units.size(), UNIT_W'($urandom_range(16'hE000, 16'hFFFF)));
            end else begin
               units.insert(units.size(), UNIT_W'($urandom_range(HIGH_FIRST, HIGH_LAST)));
               units.insert(units.size(), UNIT_W'($urandom_range(LOW_FIRST, LOW_LAST)));
            end
         end
         if (kind < 15)
            units.insert($urandom_range(0, units.size()), UNIT_W'($urandom_range(0, 16'hFFFF)));
         else if (kind < 25)
            units.insert($urandom_range(0, units.size()),
                         UNIT_W'($urandom_range(HIGH_FIRST, LOW_LAST)));
         else if (kind < 30 && units.size() > 1)
            units.delete(units.size() - 1);
      end
      for (int k = 0; k < units.size(); k++) begin
         // rare limit change in the middle of a text
         if (k > 0 && $urandom_range(0, 59) == 0) set_limit(pick_limit());
         send_unit(units[k], k == units.size() - 1, 1'b0, '0);
      end
   endtask

   // Receiver: random stalls, none while ready_steady is set.
   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!ready_steady) stall_left = pick_gap();
         end
      end
   end

   // Result checker: every completed transaction on rsp_* against the
   // oldest queued expectation.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_queue.size() == 0) begin
            if (fail_count < REPORT_MAX)
               $display("%0t: result with nothing queued: cp=%h v=%b st=%0d done=%b",
                        $realtime, rsp_codepoint, rsp_codepoint_valid, rsp_status,
                        rsp_text_done);
            fail_count++;
         end else begin
            want = decoded_queue.pop_front();
            if (rsp_codepoint !== want.codepoint ||
                rsp_codepoint_valid !== want.codepoint_valid ||
                rsp_status !== want.status ||
                rsp_text_done !== want.text_done) begin
               if (fail_count < REPORT_MAX) begin
                  $write("%0t: mismatch: expected cp=%h v=%b st=%0d done=%b, ",
                         $realtime, want.codepoint, want.codepoint_valid,
                         want.status, want.text_done);
                  $display("got cp=%h v=%b st=%0d done=%b", rsp_codepoint,
                           rsp_codepoint_valid, rsp_status, rsp_text_done);
               end
               fail_count++;
            end
         end
      end
   end

   // Stimulus.
   initial begin
      int phase_start;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed table: code unit, end flag, limit write, typed result.
      // BMP extremes and the full pair range under the reset limit
      add_row(16'h0000, 1'b0, 1'b0, '0, 1'b1, 21'h000000, 1'b1, ST_OK);
      add_row(16'hFFFF, 1'b1, 1'b0, '0, 1'b1, 21'h00FFFF, 1'b1, ST_OK);
      add_row(16'hD800, 1'b0, 1'b0, '0, 1'b1, 21'h000000, 1'b0, ST_OK);
      add_row(16'hDC00, 1'b1, 1'b0, '0, 1'b1, 21'h010000, 1'b1, ST_OK);
      add_row(16'hDBFF, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, ST_OK);
      add_row(16'hDFFF, 1'b1, 1'b0, '0, 1'b1, 21'h10FFFF, 1'b1, ST_OK);
      // high surrogate on the last unit; lone low surrogate
      add_row(16'hD800, 1'b1, 1'b0, '0, 1'b1, '0, 1'b0, ST_HIGH_AT_END);
      add_row(16'hDC00, 1'b1, 1'b0, '0, 1'b1, '0, 1'b0, ST_LONE_LOW);
      // bad pair, then sticky on the next unit
      add_row(16'hD800, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, ST_OK);
      add_row(16'h0041, 1'b0, 1'b0, '0, 1'b1, '0, 1'b0, ST_BAD_PAIR);
      add_row(16'h0042, 1'b1, 1'b0, '0, 1'b1, '0, 1'b0, ST_BAD_PAIR);
      // bad pair on the last unit: high after high
      add_row(16'hDBFF, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, ST_OK);
      add_row(16'hD800, 1'b1, 1'b0, '0, 1'b1, '0, 1'b0, ST_BAD_PAIR);
      // limit zero
      add_row(16'h0041, 1'b1, 1'b1, '0, 1'b1, '0, 1'b0, ST_LIMIT_ZERO);
      // limit of one: second code point fails
      add_row(16'h0041, 1'b0, 1'b1, COUNT_W'(1), 1'b0, '0, 1'b0, ST_OK);
      add_row(16'h0042, 1'b1, 1'b0, '0, 1'b1, '0, 1'b0, ST_LIMIT_EXCEEDED);
      // limit lowered while a high half is held: low half still completes
      add_row(16'h0041, 1'b0, 1'b1, COUNT_W'(2), 1'b0, '0, 1'b0, ST_OK);
      add_row(16'hDBFF, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, ST_OK);
      add_row(16'hDC00, 1'b0, 1'b1, COUNT_W'(1), 1'b0, '0, 1'b0, ST_OK);
      add_row(16'h0042, 1'b1, 1'b0, '0, 1'b1, '0, 1'b0, ST_LIMIT_EXCEEDED);
      // all-ones limit, then back to the reset value
      add_row(16'hE000, 1'b0, 1'b1, {COUNT_W{1'b1}}, 1'b0, '0, 1'b0, ST_OK);
      add_row(16'hD7FF, 1'b1, 1'b0, '0, 1'b0, '0, 1'b0, ST_OK);
      add_row(16'h7FFF, 1'b1, 1'b1, LIMIT_RESET, 1'b0, '0, 1'b0, ST_OK);

      foreach (unit_table[i]) begin
         if (unit_table[i].load) set_limit(unit_table[i].lim);
         send_unit(unit_table[i].unit, unit_table[i].eot, unit_table[i].typed,
                   unit_table[i].want);
      end

      // Random phases: new limit and idling style each phase.
      phase_start = units_sent;
      while (units_sent - phase_start < RANDOM_UNITS) begin
         int start;
         send_steady  = ($urandom_range(0, 3) == 0);
         ready_steady = ($urandom_range(0, 3) == 0);
         set_limit(pick_limit());
         start = units_sent;
         while (units_sent - start < PHASE_UNITS) send_text();
      end

      @(negedge clock) req_valid <= 1'b0;
      while (decoded_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog.
   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
